// ===== src/ohlc_pkg.sv =====
// ohlc_pkg: shared constants, widths and types of the ohlc bar aggregator
// no dependencies
package ohlc_pkg;
	localparam int CELLS_DEF = 64;
	localparam logic [62:0] BUCKET_RESET = 63'd60000000000;

	localparam logic [2:0] REG_BUCKET_LENGTH = 3'd0;
	localparam logic [2:0] REG_PER_SYMBOL = 3'd1;
	localparam logic [2:0] REG_BOOKS_ONLY = 3'd2;
	localparam logic [2:0] REG_FILTER_COUNT = 3'd3;
	localparam logic [2:0] REG_FILTER_SYM0 = 3'd4;

	localparam logic OP_EVENT = 1'b0;
	localparam logic OP_FINALIZE = 1'b1;

	// one table row as stored in memory
	typedef struct packed {
		logic [63:0] bucket;
		logic [31:0] symbol;
		logic [63:0] open_time;
		logic [63:0] close_time;
		logic [63:0] open_price;
		logic [63:0] close_price;
		logic [63:0] high_price;
		logic [63:0] low_price;
	} cell_t;

	// request to the divider
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [62:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
		logic [63:0] remainder;
	} div_rsp_t;
endpackage

// ===== src/ohlc_divider.sv =====
// ohlc_divider: unsigned 64 by 63 bit radix-2 restoring divider, one bit per cycle
// depends on ohlc_pkg
module ohlc_divider import ohlc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [63:0] quot_q;
	logic [63:0] rem_q;
	logic [62:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted = {rem_q, quot_q[63]};
	assign trial = shifted - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quotient = quot_q;
	assign rsp.remainder = rem_q;
endmodule

// ===== src/ohlc_cell_mem.sv =====
// ohlc_cell_mem: single-port cell table with registered read data
// depends on ohlc_pkg
module ohlc_cell_mem import ohlc_pkg::*; #(
	parameter int CELLS = CELLS_DEF,
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] addr,
	input  cell_t         wr_data,
	output cell_t         rd_data
);
	cell_t mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end
endmodule

// ===== src/ohlc_bar_aggregator.sv =====
// ohlc_bar_aggregator: top level, config registers, bucket alignment, table search and update
// depends on ohlc_pkg, ohlc_divider, ohlc_cell_mem
//
// channel  dir  handshake              content
// s_axis   in   tvalid/tready          tdata: event; tuser: opcode
// m_axis   out  tvalid/tready, tlast   tdata: row; tuser: overflow
// cfg      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// one item at a time; an event passes through the divider, then the bucket start is formed,
// then the key search reads the stored cells in turn, and one update state writes the cell.
// finalize reads and emits the rows one by one, and stalls while m_axis_tready is low.
// reset clears control state and config only; the table needs no clearing
// since only rows below the used count are ever read.
module ohlc_bar_aggregator import ohlc_pkg::*; #(
	parameter int CELLS = CELLS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// is_trade[0], trade_time[64:1], trade_symbol[96:65], trade_price[160:97], zeros
	input  logic [167:0] s_axis_tdata,
	// opcode[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// row_valid[0], bucket_start[64:1], row_symbol[96:65], open[160:97],
	// high[224:161], low[288:225], close[352:289], zeros
	output logic [359:0] m_axis_tdata,
	// overflow[0]
	output logic         m_axis_tuser,
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW = $clog2(CELLS + 1);
	localparam logic [CW-1:0] CELLS_C = CW'(CELLS);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIV    = 7'b0000010,
		ST_ALIGN  = 7'b0000100,
		ST_SEARCH = 7'b0001000,
		ST_UPDATE = 7'b0010000,
		ST_FIN    = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [62:0] bucket_length_q;
	logic        per_symbol_q;
	logic        books_only_q;
	logic [2:0]  filter_count_q;
	logic [31:0] filter_sym_q [4];

	logic [CW-1:0] used_q;
	logic          overflow_q;

	logic [63:0] time_q;
	logic [31:0] key_q;
	logic [63:0] price_q;
	logic [63:0] bucket_q;
	logic [62:0] den_q;
	logic [CW-1:0] idx_q;
	logic        rd_pend_q;

	cell_t    rd_cell;
	cell_t    wr_cell;
	logic     wr_en;
	logic [AW-1:0] mem_addr;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [31:0] in_sym;
	logic        sym_ok;
	logic [2:0]  fcnt;
	logic [63:0] mag;
	logic [63:0] prod;
	logic        is_neg;
	logic        hit;
	logic        cell_live;

	logic          out_valid_q;
	logic [359:0]  out_data_q;
	logic          out_last_q;
	logic          out_ovf_q;
	logic          out_free;
	logic          out_load;

	assign in_sym = s_axis_tdata[96:65];
	assign fcnt = (filter_count_q > 3'd4) ? 3'd4 : filter_count_q;

	always_comb begin
		sym_ok = (fcnt == 3'd0);
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < fcnt && filter_sym_q[i] == in_sym) begin
				sym_ok = 1'b1;
			end
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_length_q <= BUCKET_RESET;
			per_symbol_q <= 1'b1;
			books_only_q <= 1'b0;
			filter_count_q <= '0;
			for (int i = 0; i < 4; i++) begin
				filter_sym_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BUCKET_LENGTH: bucket_length_q <= cfg_data[62:0];
				REG_PER_SYMBOL: per_symbol_q <= cfg_data[0];
				REG_BOOKS_ONLY: books_only_q <= cfg_data[0];
				REG_FILTER_COUNT: filter_count_q <= cfg_data[2:0];
				default: filter_sym_q[cfg_index[1:0]] <= cfg_data[31:0];
			endcase
		end
	end

	// negative times: ceil(|t|/d) = q + (r != 0); product fits since it is <= 2^63 + d
	assign is_neg = time_q[63];
	assign mag = is_neg ? (64'd0 - time_q) : time_q;
	assign div_req.start = (state_q == ST_DIV) && !rd_pend_q;
	assign div_req.dividend = mag;
	assign div_req.divisor = den_q;

	ohlc_divider u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	logic [63:0] qc;
	assign qc = div_rsp.quotient + {63'd0, is_neg && (div_rsp.remainder != 64'd0)};
	// the quotient times the divisor is one wide multiply; split into three 32x32 products
	logic [63:0] pp_q [3];
	always_ff @(posedge clk) begin
		if (div_rsp.done) begin
			pp_q[0] <= qc[31:0] * {32'd0, den_q[31:0]};
			pp_q[1] <= qc[63:32] * {32'd0, den_q[31:0]};
			pp_q[2] <= qc[31:0] * {33'd0, den_q[62:32]};
		end
	end
	logic [64:0] prod_w;
	assign prod_w = {1'b0, pp_q[0]} + {1'b0, pp_q[1][31:0], 32'd0}
		+ {1'b0, pp_q[2][31:0], 32'd0};
	assign prod = prod_w[63:0];

	assign hit = rd_cell.bucket == bucket_q && rd_cell.symbol == key_q;
	assign cell_live = idx_q < used_q;
	assign mem_addr = idx_q[AW-1:0];

	always_comb begin
		wr_cell = rd_cell;
		wr_en = 1'b0;
		if (state_q == ST_UPDATE) begin
			wr_en = 1'b1;
			if (cell_live) begin
				if ($signed(time_q) < $signed(rd_cell.open_time)) begin
					wr_cell.open_time = time_q;
					wr_cell.open_price = price_q;
				end
				if ($signed(rd_cell.close_time) < $signed(time_q)) begin
					wr_cell.close_time = time_q;
					wr_cell.close_price = price_q;
				end
				if ($signed(rd_cell.high_price) < $signed(price_q)) begin
					wr_cell.high_price = price_q;
				end
				if ($signed(price_q) < $signed(rd_cell.low_price)) begin
					wr_cell.low_price = price_q;
				end
			end else begin
				wr_cell.bucket = bucket_q;
				wr_cell.symbol = key_q;
				wr_cell.open_time = time_q;
				wr_cell.close_time = time_q;
				wr_cell.open_price = price_q;
				wr_cell.close_price = price_q;
				wr_cell.high_price = price_q;
				wr_cell.low_price = price_q;
			end
		end
	end

	ohlc_cell_mem #(.CELLS(CELLS)) u_mem (
		.clk(clk), .wr_en(wr_en), .addr(mem_addr), .wr_data(wr_cell), .rd_data(rd_cell)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = out_free && ((state_q == ST_FIN && used_q == '0)
		|| (state_q == ST_EMIT && !rd_pend_q));

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			time_q <= s_axis_tdata[64:1];
			key_q <= per_symbol_q ? in_sym : 32'd0;
			price_q <= s_axis_tdata[160:97];
			den_q <= (bucket_length_q == 63'd0) ? 63'd1 : bucket_length_q;
		end
		if (state_q == ST_ALIGN && !rd_pend_q) begin
			if (!is_neg) begin
				bucket_q <= prod;
			end else if (prod_w > 65'h0_8000_0000_0000_0000) begin
				bucket_q <= 64'h8000_0000_0000_0000;
			end else begin
				bucket_q <= 64'd0 - prod;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			overflow_q <= 1'b0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q <= 1'b0;
			out_ovf_q <= 1'b0;
			out_data_q <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					if (s_axis_tvalid) begin
						if (s_axis_tuser == OP_FINALIZE) begin
							state_q <= ST_FIN;
						end else if (s_axis_tdata[0] && !books_only_q && sym_ok) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					// rd_pend_q marks that the divider was started
					rd_pend_q <= 1'b1;
					if (div_rsp.done) begin
						state_q <= ST_ALIGN;
					end
				end
				ST_ALIGN: begin
					// rd_pend_q first waits out the product registers, then the sum is registered
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						state_q <= ST_SEARCH;
						idx_q <= '0;
						rd_pend_q <= 1'b1;
					end
				end
				ST_SEARCH: begin
					// memory address is idx_q; rd_pend_q waits out the read latency
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						if (!cell_live) begin
							if (used_q >= CELLS_C) begin
								overflow_q <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								state_q <= ST_UPDATE;
							end
						end
					end else if (hit) begin
						state_q <= ST_UPDATE;
					end else begin
						idx_q <= idx_q + CW'(1);
						rd_pend_q <= 1'b1;
					end
				end
				ST_UPDATE: begin
					if (!cell_live) begin
						used_q <= used_q + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_FIN: begin
					if (used_q == '0) begin
						if (out_free) begin
							out_data_q <= '0;
							out_ovf_q <= overflow_q;
							out_last_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= '0;
						rd_pend_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
					end else if (out_free) begin
						out_data_q <= {7'd0, rd_cell.close_price, rd_cell.low_price,
							rd_cell.high_price, rd_cell.open_price, rd_cell.symbol,
							rd_cell.bucket, 1'b1};
						out_ovf_q <= overflow_q;
						out_last_q <= (idx_q + CW'(1) == used_q);
						if (idx_q + CW'(1) == used_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + CW'(1);
							rd_pend_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;
	assign m_axis_tuser = out_ovf_q;
	assign m_axis_tlast = out_last_q;
endmodule

// ===== tb/tb_ohlc_bar_aggregator.sv =====
// tb_ohlc_bar_aggregator: self-checking testbench of the ohlc bar aggregator
// depends on ohlc_pkg and ohlc_bar_aggregator; drives trade events and finalize runs,
// predicts every emitted row and compares it field by field
`timescale 1ns / 1ps

module tb_ohlc_bar_aggregator;
	import ohlc_pkg::*;

	localparam int NCELLS = CELLS_DEF;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic        opcode;
		logic        is_trade;
		logic [63:0] t;
		logic [31:0] sym;
		logic [63:0] price;
	} event_t;

	typedef struct packed {
		logic        row_valid;
		logic [63:0] bucket;
		logic [31:0] sym;
		logic [63:0] open_p;
		logic [63:0] high_p;
		logic [63:0] low_p;
		logic [63:0] close_p;
		logic        ovf;
		logic        last;
	} bar_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [167:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [359:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	ohlc_bar_aggregator uut (.*);

	initial forever #4 clk = ~clk;

	// predictor state
	logic [62:0] bar_width;
	logic        keyed_by_sym, books_only_m;
	logic [2:0]  allow_count;
	logic [31:0] allow_sym[4];
	logic [63:0] c_bucket[NCELLS], c_otime[NCELLS], c_ctime[NCELLS];
	logic [63:0] c_open[NCELLS], c_close[NCELLS], c_high[NCELLS], c_low[NCELLS];
	logic [31:0] c_sym[NCELLS];
	int          cells_used;
	logic        table_full_seen;

	event_t pending_events[$];
	bar_t   expected_bars[$];
	int     errors = 0, rows_seen = 0, events_sent = 0, finals_sent = 0;
	int     idle_cycles = 0;
	bit     hold_sender = 0;

	task automatic queue_event(event_t e);
		pending_events = {pending_events, e};
	endtask

	task automatic queue_bar(bar_t r);
		expected_bars = {expected_bars, r};
	endtask

	function automatic event_t decode_event(logic op, logic [167:0] d);
		event_t e;
		e.opcode = op;
		e.is_trade = d[0];
		e.t = d[64:1];
		e.sym = d[96:65];
		e.price = d[160:97];
		return e;
	endfunction

	function automatic logic [63:0] floor_bucket(logic [63:0] t);
		logic [63:0] d, mag, q, prod;
		d = (bar_width == 0) ? 64'd1 : {1'b0, bar_width};
		if (!t[63]) return (t / d) * d;
		mag = -t;
		q = (mag + d - 64'd1) / d;
		prod = q * d;
		if (prod > 64'h8000_0000_0000_0000) return 64'h8000_0000_0000_0000;
		return -prod;
	endfunction

	function automatic bit sym_allowed(logic [31:0] s);
		int n;
		n = (allow_count > 4) ? 4 : allow_count;
		if (n == 0) return 1;
		for (int i = 0; i < n; i++)
			if (allow_sym[i] == s) return 1;
		return 0;
	endfunction

	task automatic apply_trade(event_t e);
		logic [63:0] b;
		logic [31:0] k;
		int i;
		if (!e.is_trade || books_only_m || !sym_allowed(e.sym)) return;
		b = floor_bucket(e.t);
		k = keyed_by_sym ? e.sym : 32'd0;
		for (i = 0; i < cells_used; i++)
			if (c_bucket[i] == b && c_sym[i] == k) break;
		if (i < cells_used) begin
			if ($signed(e.t) < $signed(c_otime[i])) begin
				c_otime[i] = e.t;
				c_open[i] = e.price;
			end
			if ($signed(c_ctime[i]) < $signed(e.t)) begin
				c_ctime[i] = e.t;
				c_close[i] = e.price;
			end
			if ($signed(c_high[i]) < $signed(e.price)) c_high[i] = e.price;
			if ($signed(e.price) < $signed(c_low[i])) c_low[i] = e.price;
		end else if (cells_used >= NCELLS) begin
			table_full_seen = 1;
		end else begin
			c_bucket[i] = b; c_sym[i] = k;
			c_otime[i] = e.t; c_ctime[i] = e.t;
			c_open[i] = e.price; c_close[i] = e.price;
			c_high[i] = e.price; c_low[i] = e.price;
			cells_used++;
		end
	endtask

	task automatic predict_bars(event_t e);
		bar_t r;
		if (e.opcode == OP_EVENT) begin
			apply_trade(e);
			return;
		end
		if (cells_used == 0) begin
			r = '0;
			r.ovf = table_full_seen;
			r.last = 1;
			queue_bar(r);
			return;
		end
		for (int k = 0; k < cells_used; k++) begin
			r.row_valid = 1; r.bucket = c_bucket[k]; r.sym = c_sym[k];
			r.open_p = c_open[k]; r.high_p = c_high[k]; r.low_p = c_low[k];
			r.close_p = c_close[k]; r.ovf = table_full_seen;
			r.last = (k == cells_used - 1);
			queue_bar(r);
		end
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predict_bars(decode_event(s_axis_tuser, s_axis_tdata));
			if (s_axis_tuser == OP_FINALIZE) finals_sent++; else events_sent++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (send_gap > 0 || hold_sender || pending_events.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				if (send_gap > 0) send_gap <= send_gap - 1;
			end else begin
				event_t e;
				e = pending_events.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= e.opcode;
				s_axis_tdata <= {7'd0, e.price, e.sym, e.t, e.is_trade};
				send_gap <= gap_len();
			end
		end
	end

	// monitor
	int stall = 0;
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			bar_t got, want;
			got = {m_axis_tdata[0], m_axis_tdata[64:1], m_axis_tdata[96:65],
				m_axis_tdata[160:97], m_axis_tdata[224:161], m_axis_tdata[288:225],
				m_axis_tdata[352:289], m_axis_tuser, m_axis_tlast};
			rows_seen++;
			if (expected_bars.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected row %h", got);
			end else begin
				want = expected_bars.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("row mismatch: valid %b/%b bucket %h/%h sym %h/%h",
							want.row_valid, got.row_valid, want.bucket, got.bucket,
							want.sym, got.sym);
						$display("  o %h/%h h %h/%h l %h/%h c %h/%h ovf %b/%b last %b/%b",
							want.open_p, got.open_p, want.high_p, got.high_p,
							want.low_p, got.low_p, want.close_p, got.close_p,
							want.ovf, got.ovf, want.last, got.last);
					end
				end
			end
		end
		if (stall > 0) begin
			m_axis_tready <= 1'b0;
			stall <= stall - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0) stall <= gap_len();
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BUCKET_LENGTH: bar_width = val[62:0];
			REG_PER_SYMBOL: keyed_by_sym = val[0];
			REG_BOOKS_ONLY: books_only_m = val[0];
			REG_FILTER_COUNT: allow_count = val[2:0];
			default: allow_sym[idx - REG_FILTER_SYM0] = val[31:0];
		endcase
	endtask

	// block is idle once queues drain and the last event has left the search
	task automatic drain();
		wait (pending_events.size() == 0 && !s_axis_tvalid);
		wait (expected_bars.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic event_t mk_trade(logic [63:0] t, logic [31:0] s, logic [63:0] p);
		return '{opcode: OP_EVENT, is_trade: 1'b1, t: t, sym: s, price: p};
	endfunction

	function automatic event_t mk_final();
		event_t e;
		e.opcode = OP_FINALIZE;
		e.is_trade = 1'($urandom_range(0, 1));
		e.t = {$urandom, $urandom};
		e.sym = $urandom;
		e.price = {$urandom, $urandom};
		return e;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;

	task automatic random_phase(int n, int nsym, logic [63:0] span);
		logic [31:0] syms[4];
		logic [63:0] base;
		event_t e;
		for (int i = 0; i < 4; i++) syms[i] = (i == 3) ? $urandom : $urandom_range(0, 9);
		base = ($urandom_range(0, 3) == 0) ? rnd64() : {{32{1'b0}}, $urandom};
		for (int i = 0; i < n; i++) begin
			int p;
			p = $urandom_range(0, 99);
			if (p < 85) begin
				e = mk_trade(base + ($urandom % span) - span / 2,
					syms[$urandom_range(0, nsym - 1)], rnd64());
				if ($urandom_range(0, 4) == 0) e.price = 64'($urandom_range(0, 10));
				if ($urandom_range(0, 9) == 0) e.t = rnd64();
				e.is_trade = ($urandom_range(0, 9) != 0);
			end else if (p < 92) begin
				e = mk_trade(rnd64(), $urandom, rnd64());
			end else begin
				e = mk_final();
			end
			queue_event(e);
		end
		queue_event(mk_final());
	endtask

	initial begin
		bar_width = BUCKET_RESET;
		keyed_by_sym = 1; books_only_m = 0; allow_count = 0;
		for (int i = 0; i < 4; i++) allow_sym[i] = 0;
		cells_used = 0;
		table_full_seen = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty finalize, extremes, ties, reset config
		queue_event(mk_final());
		queue_event(mk_trade(MINV, 32'hffff_ffff, MAXV));
		queue_event(mk_trade(MINV + 1, 32'hffff_ffff, MINV));
		queue_event(mk_trade(MAXV, 0, 64'd5));
		queue_event(mk_trade(MAXV - 1, 0, 64'd7));
		queue_event(mk_trade(64'd100, 7, 64'd10));
		queue_event(mk_trade(64'd100, 7, 64'd20));
		queue_event(mk_trade(-64'd1, 7, -64'd3));
		begin
			event_t e;
			e = mk_trade(64'd200, 7, 64'd99);
			e.is_trade = 0;
			queue_event(e);
		end
		queue_event(mk_final());
		drain();

		// zero width, shared key, filter of more than four, books only on
		write_reg(REG_BUCKET_LENGTH, 64'd0);
		write_reg(REG_PER_SYMBOL, 64'd0);
		write_reg(REG_FILTER_COUNT, 64'd7);
		write_reg(REG_FILTER_SYM0, 64'd7);
		write_reg(REG_FILTER_SYM0 + 3'd1, 64'hffff_ffff);
		write_reg(REG_FILTER_SYM0 + 3'd2, 64'd3);
		write_reg(REG_FILTER_SYM0 + 3'd3, 64'd9);
		queue_event(mk_trade(64'd5, 7, 64'd1));
		queue_event(mk_trade(64'd5, 8, 64'd2));
		queue_event(mk_trade(64'd5, 9, 64'd3));
		queue_event(mk_trade(64'd5, 32'hffff_ffff, 64'd4));
		queue_event(mk_final());
		drain();
		write_reg(REG_BOOKS_ONLY, 64'd1);
		queue_event(mk_trade(64'd6, 7, 64'd1));
		queue_event(mk_final());
		drain();

		// largest width around zero, then random phases
		write_reg(REG_BOOKS_ONLY, 64'd0);
		write_reg(REG_FILTER_COUNT, 64'd0);
		write_reg(REG_BUCKET_LENGTH, 64'hffff_ffff_ffff_ffff);
		queue_event(mk_trade(-64'd10, 1, 64'd1));
		queue_event(mk_trade(64'd10, 1, 64'd2));
		queue_event(mk_final());
		drain();

		write_reg(REG_PER_SYMBOL, 64'd1);
		write_reg(REG_BUCKET_LENGTH, 64'd1000);
		random_phase(45, 4, 64'd20000);
		// sender holds off until every expected row is back
		wait (pending_events.size() < 20);
		hold_sender = 1;
		wait (!s_axis_tvalid && expected_bars.size() == 0);
		hold_sender = 0;
		drain();

		write_reg(REG_FILTER_COUNT, 64'd2);
		write_reg(REG_FILTER_SYM0, 64'd1);
		write_reg(REG_FILTER_SYM0 + 3'd1, 64'd3);
		write_reg(REG_BUCKET_LENGTH, 64'd1);
		random_phase(35, 4, 64'd8);
		drain();

		// flood the table past its size to hit overflow
		write_reg(REG_FILTER_COUNT, 64'd0);
		write_reg(REG_BUCKET_LENGTH, 64'd3);
		for (int i = 0; i < 50; i++)
			queue_event(mk_trade(64'd1000000 + 3 * i, $urandom_range(0, 1),
				rnd64()));
		queue_event(mk_final());
		random_phase(30, 2, 64'd400);
		drain();

		$display("sent %0d events and %0d finalize runs, checked %0d rows",
			events_sent, finals_sent, rows_seen);
		$display("covered filter, books-only, shared keys, extreme times and table overflow");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
src/ohlc_pkg.sv
src/ohlc_divider.sv
src/ohlc_cell_mem.sv
src/ohlc_bar_aggregator.sv
tb/tb_ohlc_bar_aggregator.sv
